/* rtl/mexp_pkg.sv */
// mexp_pkg: shared constants and types for the modular exponentiation block.
// Used by modular_exponentiation; no dependencies.
package mexp_pkg;

  localparam int unsigned EXP_BITS_DEF = 32;
  localparam int unsigned MOD_BITS_DEF = 30;

  localparam int unsigned BASE_W = 30;
  localparam int unsigned EXP_W  = 32;
  localparam int unsigned CFG_W  = 30;
  localparam int unsigned RES_W  = 30;

  localparam logic [CFG_W-1:0] MODULUS_RESET = 30'd1000000007;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_BIT,
    S_MUL,
    S_SQR,
    S_OUT
  } mexp_state_e;

endpackage

/* rtl/modular_exponentiation.sv */
// modular_exponentiation: top level, square-and-multiply sequencer around one
// shared bit-serial modular multiplier. Depends on mexp_pkg and mexp_mulmod.
//
// Computes base^exponent mod modulus, scanning the exponent from its LSB.
// The block takes one word at a time and is not ready while it works. All
// arithmetic goes through the single mexp_mulmod unit (OPW = max(30,
// MOD_BITS)): one product for base reduction, then per exponent bit a
// decision state, one product if the bit is set and one squaring. A modulus
// below 2 returns 0 in the cycle after the input handshake. The modulus
// register may only be written while idle.
module modular_exponentiation #(
  parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF,
  parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mexp_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mexp_pkg::BASE_W-1:0]  base_i,
  input  logic [mexp_pkg::EXP_W-1:0]   exponent_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mexp_pkg::RES_W-1:0]   power_result_o
);

  localparam int unsigned OPW = (MOD_BITS > mexp_pkg::BASE_W) ? MOD_BITS : mexp_pkg::BASE_W;
  localparam int unsigned CNT_W = $clog2(EXP_BITS + 1);

  mexp_pkg::mexp_state_e state_q, state_d;

  logic [mexp_pkg::CFG_W-1:0] mod_q;
  logic [EXP_BITS-1:0]        exp_q, exp_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [MOD_BITS-1:0]        acc_q, acc_d, sq_q, sq_d;
  logic [MOD_BITS-1:0]        m;

  logic                mm_start, mm_done;
  logic [MOD_BITS-1:0] mm_a, mm_r;
  logic [OPW-1:0]      mm_b;

  assign m = MOD_BITS'(mod_q);

  mexp_mulmod #(
    .MOD_BITS (MOD_BITS),
    .OPW      (OPW)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .m_i     (m),
    .done_o  (mm_done),
    .r_o     (mm_r)
  );

  always_comb begin
    state_d  = state_q;
    exp_d    = exp_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    sq_d     = sq_q;
    mm_start = 1'b0;
    mm_a     = sq_q;
    mm_b     = OPW'(sq_q);
    unique case (state_q)
      mexp_pkg::S_IDLE: begin
        mm_a = MOD_BITS'(1);
        mm_b = OPW'(base_i);
        if (in_valid_i) begin
          exp_d = EXP_BITS'(exponent_i);
          cnt_d = CNT_W'(EXP_BITS);
          if (m < MOD_BITS'(2)) begin
            acc_d   = '0;
            state_d = mexp_pkg::S_OUT;
          end else begin
            mm_start = 1'b1;
            state_d  = mexp_pkg::S_RED;
          end
        end
      end
      mexp_pkg::S_RED: begin
        if (mm_done) begin
          sq_d    = mm_r;
          acc_d   = MOD_BITS'(1);
          state_d = mexp_pkg::S_BIT;
        end
      end
      mexp_pkg::S_BIT: begin
        if (cnt_q == '0) begin
          state_d = mexp_pkg::S_OUT;
        end else if (exp_q[0]) begin
          mm_b     = OPW'(acc_q);
          mm_start = 1'b1;
          state_d  = mexp_pkg::S_MUL;
        end else begin
          mm_start = 1'b1;
          state_d  = mexp_pkg::S_SQR;
        end
      end
      mexp_pkg::S_MUL: begin
        if (mm_done) begin
          acc_d    = mm_r;
          mm_start = 1'b1;
          state_d  = mexp_pkg::S_SQR;
        end
      end
      mexp_pkg::S_SQR: begin
        if (mm_done) begin
          sq_d    = mm_r;
          exp_d   = exp_q >> 1;
          cnt_d   = cnt_q - 1'b1;
          state_d = mexp_pkg::S_BIT;
        end
      end
      mexp_pkg::S_OUT: begin
        if (out_ready_i) begin
          state_d = mexp_pkg::S_IDLE;
        end
      end
      default: state_d = mexp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mexp_pkg::S_IDLE;
      mod_q   <= mexp_pkg::MODULUS_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= exp_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    sq_q  <= sq_d;
  end

  assign in_ready_o     = (state_q == mexp_pkg::S_IDLE);
  assign out_valid_o    = (state_q == mexp_pkg::S_OUT);
  assign power_result_o = mexp_pkg::RES_W'(acc_q);

endmodule

/* rtl/mexp_mulmod.sv */
// mexp_mulmod: bit-serial modular multiplier, one multiplier bit per cycle.
// Computes (a * b) mod m for a < m. Depends on nothing outside this file.
module mexp_mulmod #(
  parameter int unsigned MOD_BITS = 30,
  parameter int unsigned OPW      = 30
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [MOD_BITS-1:0] a_i,
  input  logic [OPW-1:0]      b_i,
  input  logic [MOD_BITS-1:0] m_i,
  output logic                done_o,
  output logic [MOD_BITS-1:0] r_o
);

  localparam int unsigned TW = MOD_BITS + 2;
  localparam int unsigned CW = $clog2(OPW + 1);

  logic [MOD_BITS-1:0] a_q, r_q, r_d;
  logic [OPW-1:0]      b_q;
  logic [CW-1:0]       cnt_q;
  logic                run_q, done_q;
  logic [TW-1:0]       t, mm, mm2;

  always_comb begin
    mm  = TW'(m_i);
    mm2 = mm << 1;
    t   = (TW'(r_q) << 1) + (b_q[OPW-1] ? TW'(a_q) : '0);
    if (t >= mm2) begin
      r_d = MOD_BITS'(t - mm2);
    end else if (t >= mm) begin
      r_d = MOD_BITS'(t - mm);
    end else begin
      r_d = MOD_BITS'(t);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(OPW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      r_q <= '0;
    end else if (run_q) begin
      b_q <= b_q << 1;
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule
